@@ hw/rtl/tsb_pkg.sv @@
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants of the text-mode screen buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsb_pkg;

  // Field widths of the request and response transactions
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CUR_W  = 11;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Strobes from the sequencer to the cell memory
  typedef struct packed {
    logic wr_char;
    logic wr_attr;
    logic rd;
  } mem_ctl_t;

endpackage

@@ hw/rtl/tsb_req_if.sv @@
// ----------------------------------------------------------------------------
// tsb_req_if
// Request channel: command, character byte and read coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsb_req_if import tsb_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;

  modport source (output valid, output cmd, output char_code, output row, output col,
                  input ready);
  modport sink   (input valid, input cmd, input char_code, input row, input col,
                  output ready);

endinterface

@@ hw/rtl/tsb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tsb_rsp_if
// Response channel: cell read back and cursor after the command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsb_rsp_if import tsb_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic [CUR_W-1:0]  cursor_pos;

  modport source (output valid, output cell_char, output cell_attr, output cursor_pos,
                  input ready);
  modport sink   (input valid, input cell_char, input cell_attr, input cursor_pos,
                  output ready);

endinterface

@@ hw/rtl/tsb_cell_mem.sv @@
// ----------------------------------------------------------------------------
// tsb_cell_mem
// Character and attribute arrays: one write port with per-byte strobes and
// one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsb_cell_mem import tsb_pkg::*; #(
  parameter int DEPTH = 2000
) (
  input  logic                       clk_i,
  input  mem_ctl_t                   ctl_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [CHAR_W-1:0]          wchar_i,
  input  logic [ATTR_W-1:0]          wattr_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [CHAR_W-1:0]          rchar_o,
  output logic [ATTR_W-1:0]          rattr_o
);

  logic [CHAR_W-1:0] char_mem [DEPTH];
  logic [ATTR_W-1:0] attr_mem [DEPTH];
  logic [CHAR_W-1:0] rchar_q;
  logic [ATTR_W-1:0] rattr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_char) begin
      char_mem[waddr_i] <= wchar_i;
    end
    if (ctl_i.wr_attr) begin
      attr_mem[waddr_i] <= wattr_i;
    end
    // hold the last read data unless a new read is issued
    if (ctl_i.rd) begin
      rchar_q <= char_mem[raddr_i];
      rattr_q <= attr_mem[raddr_i];
    end
  end

  assign rchar_o = rchar_q;
  assign rattr_o = rattr_q;

endmodule

@@ hw/rtl/text_mode_screen_buffer.sv @@
// ----------------------------------------------------------------------------
// text_mode_screen_buffer
// Text screen of ROWS x COLUMNS character/attribute cells with a linear
// cursor. Requests arrive on req_i (valid/ready); every request yields one
// transaction on rsp_o carrying the read cell (zero unless a read) and the
// cursor after the command. cfg_we_i/cfg_data_i set the attribute byte for
// newly written cells; write it only while the block is idle.
// Each request is worked off by the sequencer before the next one is
// accepted (req_i.ready is high only in the idle state):
//   read, erase, plain character: at most one cell access; unused command: none
//   newline: blanks cells up to the next row start (up to COLUMNS)
//   put at end of screen first scrolls the screen up one row
// rsp_o is driven from a response register, loaded once a command finishes and the register is free.
// The sequencer walks the single write port of the cell memory one cell
// per cycle for fills, copies and clears.
// After reset the block sweeps all ROWS*COLUMNS cells to blank/default
// attribute before req_i.ready rises.
// A stalled receiver lets one more request in: the response register holds
// its transaction, the next result waits in the sequencer with req_i.ready
// low, and both advance once the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mode_screen_buffer import tsb_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsb_req_if.sink           req_i,
  tsb_rsp_if.source         rsp_o,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_data_i
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);      // cell address
  localparam int CW    = $clog2(CELLS + 1);  // cursor, may equal CELLS
  localparam int COLW  = $clog2(COLUMNS);    // column of the cursor
  localparam int IDX_W = AW + ROW_W + COL_W; // read index before truncation

  localparam logic [CW-1:0]   CELLS_C   = CW'(CELLS);
  localparam logic [CW-1:0]   COLS_CUR  = CW'(COLUMNS);
  localparam logic [AW-1:0]   COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0]   COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [COLW-1:0] LAST_COL  = COLW'(COLUMNS - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_PUT   = 8'b0000_0100,
    S_COPY  = 8'b0000_1000,
    S_BLANK = 8'b0001_0000,
    S_ERASE = 8'b0010_0000,
    S_READ  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [COLW-1:0]   col_q, col_d;       // cursor modulo COLUMNS
  logic [AW-1:0]     scan_q, scan_d;     // sweep address for clear and scroll
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic              in_range_q, in_range_d;
  logic [CHAR_W-1:0] res_char_q, res_char_d;
  logic [ATTR_W-1:0] res_attr_q, res_attr_d;
  logic [ATTR_W-1:0] attr_q;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [ATTR_W-1:0] out_attr_q, out_attr_d;
  logic [CUR_W-1:0]  out_cur_q, out_cur_d;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wchar, rchar;
  logic [ATTR_W-1:0] wattr, rattr;

  logic              accept, slot_free, finish, load;
  logic [CHAR_W-1:0] fin_char;
  logic [ATTR_W-1:0] fin_attr;
  logic              rd_in_range;
  logic [IDX_W-1:0]  rd_lin;
  logic [CW+CUR_W-1:0] cur_ext;

  // Cell memory ------------------------------------------------------------
  tsb_cell_mem #(
    .DEPTH (CELLS)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wchar_i (wchar),
    .wattr_i (wattr),
    .raddr_i (raddr),
    .rchar_o (rchar),
    .rattr_o (rattr)
  );

  // Request side -----------------------------------------------------------
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Linear index of the requested cell; only used when inside the screen
  assign rd_lin      = IDX_W'(req_i.row) * IDX_W'(COLUMNS) + IDX_W'(req_i.col);
  assign rd_in_range = (int'(req_i.row) < ROWS) && (int'(req_i.col) < COLUMNS);

  // The response register is free if empty or being emptied this cycle
  assign slot_free = !out_valid_q || rsp_o.ready;

  // Sequencer --------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    col_d      = col_q;
    scan_d     = scan_q;
    ch_d       = ch_q;
    in_range_d = in_range_q;
    res_char_d = res_char_q;
    res_attr_d = res_attr_q;
    mem_ctl    = '0;
    waddr      = '0;
    wchar      = '0;
    wattr      = '0;
    raddr      = '0;
    finish     = 1'b0;
    fin_char   = '0;
    fin_attr   = '0;

    unique case (state_q)
      S_CLEAR: begin
        // blank every cell after reset
        mem_ctl.wr_char = 1'b1;
        mem_ctl.wr_attr = 1'b1;
        waddr           = scan_q;
        wchar           = BLANK_CHAR;
        wattr           = DEFAULT_ATTR;
        if (scan_q == LAST_ADDR) begin
          scan_d  = '0;
          state_d = S_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          ch_d       = req_i.char_code;
          in_range_d = rd_in_range;
          res_char_d = '0;
          res_attr_d = '0;
          unique case (cmd_e'(req_i.cmd))
            CMD_PUT: begin
              if (cursor_q == CELLS_C) begin
                scan_d  = '0;
                state_d = S_COPY;
              end else begin
                state_d = S_PUT;
              end
            end
            CMD_ERASE: state_d = S_ERASE;
            CMD_READ: begin
              mem_ctl.rd = 1'b1;
              raddr      = rd_in_range ? rd_lin[AW-1:0] : '0;
              state_d    = S_READ;
            end
            default: state_d = S_EMIT;
          endcase
        end
      end

      S_PUT: begin
        // write one cell; a newline keeps filling up to the next row start
        mem_ctl.wr_char = 1'b1;
        mem_ctl.wr_attr = 1'b1;
        waddr           = AW'(cursor_q);
        wchar           = (ch_q == NEWLINE_CHAR) ? BLANK_CHAR : ch_q;
        wattr           = attr_q;
        cursor_d        = cursor_q + 1'b1;
        col_d           = (col_q == LAST_COL) ? '0 : col_q + 1'b1;
        if ((ch_q == NEWLINE_CHAR) && (col_d != '0) && (cursor_d != CELLS_C)) begin
          state_d = S_PUT;
        end else begin
          finish = 1'b1;
        end
      end

      S_COPY: begin
        // read the cell one row down, write the previous read one row up
        if (scan_q != COPY_END) begin
          mem_ctl.rd = 1'b1;
          raddr      = scan_q + COLS_A;
        end
        if (scan_q != '0) begin
          mem_ctl.wr_char = 1'b1;
          mem_ctl.wr_attr = 1'b1;
          waddr           = scan_q - 1'b1;
          wchar           = rchar;
          wattr           = rattr;
        end
        if (scan_q == COPY_END) begin
          state_d = S_BLANK;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_BLANK: begin
        // blank the characters of the last row, its attributes stay
        mem_ctl.wr_char = 1'b1;
        waddr           = scan_q;
        wchar           = BLANK_CHAR;
        if (scan_q == LAST_ADDR) begin
          scan_d   = '0;
          cursor_d = cursor_q - COLS_CUR;
          state_d  = S_PUT;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_ERASE: begin
        // ignored at the home position
        if (cursor_q != '0) begin
          mem_ctl.wr_char = 1'b1;
          waddr           = AW'(cursor_q - 1'b1);
          wchar           = BLANK_CHAR;
          cursor_d        = cursor_q - 1'b1;
          col_d           = (col_q == '0) ? LAST_COL : col_q - 1'b1;
        end
        finish = 1'b1;
      end

      S_READ: begin
        if (in_range_q) begin
          fin_char = rchar;
          fin_attr = rattr;
        end
        finish = 1'b1;
      end

      S_EMIT: begin
        fin_char = res_char_q;
        fin_attr = res_attr_q;
        finish   = 1'b1;
      end

      default: state_d = S_IDLE;
    endcase

    // hand the result over, or park it until the response register frees
    load = 1'b0;
    if (finish) begin
      if (slot_free) begin
        load    = 1'b1;
        state_d = S_IDLE;
      end else begin
        res_char_d = fin_char;
        res_attr_d = fin_attr;
        state_d    = S_EMIT;
      end
    end
  end

  // Response register ------------------------------------------------------
  assign cur_ext = {{CUR_W{1'b0}}, cursor_d};

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    out_cur_d   = out_cur_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_char_d  = fin_char;
      out_attr_d  = fin_attr;
      out_cur_d   = cur_ext[CUR_W-1:0];
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cell_char  = out_char_q;
  assign rsp_o.cell_attr  = out_attr_q;
  assign rsp_o.cursor_pos = out_cur_q;

  // Registers --------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cursor_q    <= '0;
      col_q       <= '0;
      scan_q      <= '0;
      attr_q      <= DEFAULT_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    in_range_q <= in_range_d;
    res_char_q <= res_char_d;
    res_attr_q <= res_attr_d;
    out_char_q <= out_char_d;
    out_attr_q <= out_attr_d;
    out_cur_q  <= out_cur_d;
  end

  // Assertions -------------------------------------------------------------
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CELLS_C)
    else $error("cursor beyond end of screen");

  a_col_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_q == CELLS_C) |-> (col_q == '0))
    else $error("column tracking lost at end of screen");

  a_scroll_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY || state_q == S_BLANK) |-> (cursor_q == CELLS_C))
    else $error("scroll started before end of screen");

  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q)
    else $error("response raised during clearing pass");

endmodule
